// ----- design/xobs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xobs_pkg
// Shared types, constants and helpers for the XML object boundary scanner.
// ----------------------------------------------------------------------------
package xobs_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int OUT_DEPTH_BITS = 16;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [3:0] {
        ST_INIT    = 4'd0,
        ST_DOC     = 4'd1,
        ST_OPEN    = 4'd2,
        ST_BANG    = 4'd3,
        ST_BEGIN   = 4'd4,
        ST_END     = 4'd5,
        ST_COMMENT = 4'd6,
        ST_INSTR   = 4'd7,
        ST_CDATA   = 4'd8
    } scan_state_t;

    typedef struct packed {
        logic [OUT_DEPTH_BITS-1:0] current_depth;
        logic                      object_end;
        logic                      object_start;
    } scan_result_t;

    function automatic logic [1:0] sat_inc(input logic [1:0] v);
        sat_inc = (v == 2'd3) ? 2'd3 : v + 2'd1;
    endfunction

endpackage

// ----- design/xobs_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xobs_scan
// Scanner state, nesting depth and run counters; per-byte next-state logic.
// ----------------------------------------------------------------------------
module xobs_scan
    import xobs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         accept,
    input  logic [7:0]   data_byte,
    output scan_result_t result
);

    scan_state_t             state_reg, state_next;
    logic [DEPTH_BITS-1:0]   depth_reg, depth_next;
    logic [7:0]              prev_reg;
    logic [1:0]              dash_reg, dash_next;
    logic [1:0]              bracket_reg, bracket_next;
    logic [7:0]              split_depth_reg;

    logic signed [31:0]      depth_ext;
    logic signed [31:0]      depth_next_ext;
    logic                    at_split;
    logic                    at_split_next;
    logic                    start;
    logic                    close;

    always_comb
    begin
        depth_ext      = 32'(signed'(depth_reg));
        depth_next_ext = 32'(signed'(depth_next));
        at_split       = (depth_ext == 32'(split_depth_reg));
        at_split_next  = (depth_next_ext == 32'(split_depth_reg));
    end

    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        dash_next    = dash_reg;
        bracket_next = bracket_reg;
        start        = 1'b0;
        close        = 1'b0;
        case (state_reg)
            ST_OPEN:
            begin
                if (data_byte == CH_GT)
                begin
                    state_next = ST_DOC;
                    if (prev_reg != CH_SLASH)
                        depth_next = depth_reg + DEPTH_BITS'(1);
                    else
                        close = at_split;
                end
                else if (data_byte == CH_SLASH)
                    state_next = ST_END;
                else if (data_byte == CH_QUEST)
                    state_next = ST_INSTR;
                else if (data_byte == CH_BANG)
                    state_next = ST_BANG;
                else
                    state_next = ST_BEGIN;
            end
            ST_BANG:
            begin
                if (data_byte == CH_DASH)
                begin
                    if (dash_reg != 2'd0)
                    begin
                        dash_next  = 2'd0;
                        state_next = ST_COMMENT;
                    end
                    else
                        dash_next = sat_inc(dash_reg);
                end
                else if (data_byte == CH_GT)
                begin
                    dash_next  = 2'd0;
                    state_next = ST_DOC;
                end
                else if (data_byte == CH_LBRACK)
                begin
                    dash_next  = 2'd0;
                    state_next = ST_CDATA;
                end
                else
                begin
                    dash_next  = 2'd0;
                    state_next = ST_INSTR;
                end
            end
            ST_BEGIN:
            begin
                if (data_byte == CH_GT)
                begin
                    state_next = ST_DOC;
                    if (prev_reg != CH_SLASH)
                        depth_next = depth_reg + DEPTH_BITS'(1);
                    else
                        close = at_split;
                end
            end
            ST_END:
            begin
                if (data_byte == CH_GT)
                begin
                    depth_next = depth_reg - DEPTH_BITS'(1);
                    close      = at_split_next;
                    state_next = ST_DOC;
                end
            end
            ST_COMMENT:
            begin
                if (data_byte == CH_DASH)
                    dash_next = sat_inc(dash_reg);
                else if (data_byte == CH_GT)
                begin
                    if (dash_reg >= 2'd2)
                    begin
                        dash_next  = 2'd0;
                        state_next = ST_DOC;
                    end
                end
                else
                    dash_next = 2'd0;
            end
            ST_INSTR:
            begin
                if (data_byte == CH_GT)
                    state_next = ST_DOC;
            end
            ST_CDATA:
            begin
                if (data_byte == CH_RBRACK)
                    bracket_next = sat_inc(bracket_reg);
                else if (data_byte == CH_GT)
                begin
                    if (bracket_reg >= 2'd2)
                        state_next = ST_DOC;
                    bracket_next = 2'd0;
                end
                else
                    bracket_next = 2'd0;
            end
            default:
            begin
                if (data_byte == CH_LT)
                begin
                    start = (state_reg == ST_INIT) ||
                            (at_split && (split_depth_reg != 8'd0));
                    state_next = ST_OPEN;
                end
            end
        endcase
        // a completed object clears both run counters
        if (close)
        begin
            dash_next    = 2'd0;
            bracket_next = 2'd0;
        end
    end

    always_comb
    begin
        result.object_start  = start;
        result.object_end    = close;
        result.current_depth = depth_next_ext[OUT_DEPTH_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            split_depth_reg <= 8'd0;
        else if (cfg_wr_en)
            split_depth_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            depth_reg   <= '0;
            prev_reg    <= 8'd0;
            dash_reg    <= 2'd0;
            bracket_reg <= 2'd0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            prev_reg    <= data_byte;
            dash_reg    <= dash_next;
            bracket_reg <= bracket_next;
        end
    end

    a_end_tag_pops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && state_reg == ST_END && data_byte == CH_GT
        |=> depth_reg == DEPTH_BITS'($past(depth_reg) - DEPTH_BITS'(1))
            && state_reg == ST_DOC)
        else $error("end tag close did not lower depth");

    a_start_on_lt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.object_start |=> state_reg == ST_OPEN && prev_reg == CH_LT)
        else $error("object start not on a tag open");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg) && $stable(depth_reg) && $stable(prev_reg))
        else $error("scanner state moved without a transaction");

    a_close_clears_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.object_end |=> dash_reg == 2'd0 && bracket_reg == 2'd0)
        else $error("run counters not cleared on object end");

    a_start_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(result.object_start && result.object_end))
        else $error("object start and end on the same byte");

endmodule

// ----- design/xobs_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xobs_out_reg
// Result register between the scanner and the output stream.
// ----------------------------------------------------------------------------
module xobs_out_reg
    import xobs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  scan_result_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output scan_result_t out_data
);

    logic         valid_reg;
    scan_result_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= in_data;
    end

endmodule

// ----- design/xml_object_boundary_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_object_boundary_scanner
// Marks the '<' and '>' bytes that open and close objects at a split depth.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw XML byte per transaction. m_axis returns one
//   result per byte: object_start, object_end and the nesting depth after
//   that byte. cfg_wr_en/cfg_wr_data load split_depth; write it only while
//   no byte is in flight.
// Latency: a result is on m_axis the cycle after its byte is accepted.
// Throughput: one byte per cycle unless m_axis stalls; state updates in the
//   same cycle a byte is taken; the single result register passes it on.
// Reset: scanner returns to its initial state, depth and run counters
//   clear, split_depth clears to zero, m_axis_tvalid drops.
// Stall: while m_axis_tready is low with a result held, s_axis_tready is
//   low; the held result stays until taken.
// ----------------------------------------------------------------------------
module xml_object_boundary_scanner
    import xobs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] object_start, [1] object_end,
                                        // [17:2] current_depth, [23:18] zero
);

    logic         accept;
    scan_result_t step_result;
    scan_result_t held_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    xobs_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .data_byte   (s_axis_tdata),
        .result      (step_result)
    );

    xobs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (step_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (held_result)
    );

    assign m_axis_tdata = {6'd0, held_result.current_depth,
                           held_result.object_end, held_result.object_start};

endmodule

// ----- dv/xobs_scan_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xobs_scan_checker
// Watches the byte and result streams of the XML object boundary scanner.
// It runs its own copy of the scanner state on every accepted input byte and
// queues the expected object_start, object_end and depth. Each accepted
// result is compared field by field with the oldest queued entry. Writes to
// split_depth are tracked from the configuration port.
// ----------------------------------------------------------------------------
module xobs_scan_checker
    import xobs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [0] object_start, [1] object_end,
                                        // [17:2] current_depth, [23:18] zero
    output int          mismatches,
    output int          outstanding
);

    scan_state_t           scan_st;
    logic [DEPTH_BITS-1:0] nest_lvl;
    logic [7:0]            last_byte;
    logic [1:0]            dash_cnt;
    logic [1:0]            brk_cnt;
    logic [7:0]            split_lvl;
    scan_result_t          expected_marks[$];
    scan_result_t          want;
    scan_result_t          got;
    int                    result_idx;

    function automatic logic [1:0] run_up(input logic [1:0] v);
        return (v == 2'd3) ? v : v + 2'd1;
    endfunction

    function automatic logic depth_hit();
        return int'($signed(nest_lvl)) == int'(split_lvl);
    endfunction

    function automatic logic shut_begin_tag();
        scan_st = ST_DOC;
        if (last_byte != CH_SLASH)
        begin
            nest_lvl = nest_lvl + DEPTH_BITS'(1);
            return 1'b0;
        end
        return depth_hit();
    endfunction

    task automatic predict_byte(input logic [7:0] c, output scan_result_t r);
        logic start_hit;
        logic end_hit;
        start_hit = 1'b0;
        end_hit   = 1'b0;
        case (scan_st)
            ST_OPEN:
            begin
                if (c == CH_GT)
                    end_hit = shut_begin_tag();
                else if (c == CH_SLASH)
                    scan_st = ST_END;
                else if (c == CH_QUEST)
                    scan_st = ST_INSTR;
                else if (c == CH_BANG)
                    scan_st = ST_BANG;
                else
                    scan_st = ST_BEGIN;
            end
            ST_BANG:
            begin
                if (c == CH_DASH)
                begin
                    if (dash_cnt != 2'd0)
                    begin
                        dash_cnt = 2'd0;
                        scan_st  = ST_COMMENT;
                    end
                    else
                    begin
                        dash_cnt = run_up(dash_cnt);
                    end
                end
                else
                begin
                    dash_cnt = 2'd0;
                    if (c == CH_GT)
                        scan_st = ST_DOC;
                    else if (c == CH_LBRACK)
                        scan_st = ST_CDATA;
                    else
                        scan_st = ST_INSTR;
                end
            end
            ST_BEGIN:
            begin
                if (c == CH_GT)
                    end_hit = shut_begin_tag();
            end
            ST_END:
            begin
                if (c == CH_GT)
                begin
                    nest_lvl = nest_lvl - DEPTH_BITS'(1);
                    end_hit  = depth_hit();
                    scan_st  = ST_DOC;
                end
            end
            ST_COMMENT:
            begin
                if (c == CH_DASH)
                begin
                    dash_cnt = run_up(dash_cnt);
                end
                else if (c == CH_GT)
                begin
                    if (dash_cnt >= 2'd2)
                    begin
                        dash_cnt = 2'd0;
                        scan_st  = ST_DOC;
                    end
                end
                else
                begin
                    dash_cnt = 2'd0;
                end
            end
            ST_INSTR:
            begin
                if (c == CH_GT)
                    scan_st = ST_DOC;
            end
            ST_CDATA:
            begin
                if (c == CH_RBRACK)
                begin
                    brk_cnt = run_up(brk_cnt);
                end
                else
                begin
                    if (c == CH_GT && brk_cnt >= 2'd2)
                        scan_st = ST_DOC;
                    brk_cnt = 2'd0;
                end
            end
            default:
            begin
                if (c == CH_LT)
                begin
                    if (scan_st == ST_INIT || (depth_hit() && split_lvl != 8'd0))
                        start_hit = 1'b1;
                    scan_st = ST_OPEN;
                end
            end
        endcase
        if (end_hit)
        begin
            dash_cnt = 2'd0;
            brk_cnt  = 2'd0;
        end
        last_byte       = c;
        r.object_start  = start_hit;
        r.object_end    = end_hit;
        r.current_depth = OUT_DEPTH_BITS'(int'($signed(nest_lvl)));
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] scan check, result %0d: %s", $realtime, result_idx, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_st     = ST_INIT;
            nest_lvl    = '0;
            last_byte   = 8'd0;
            dash_cnt    = 2'd0;
            brk_cnt     = 2'd0;
            split_lvl   = 8'd0;
            expected_marks.delete();
            result_idx  = 0;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = scan_result_t'(m_axis_tdata[17:0]);
                if (expected_marks.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction 0x%06h", m_axis_tdata));
                end
                else
                begin
                    want = expected_marks.pop_front();
                    if (got.object_start !== want.object_start)
                        report_mismatch($sformatf("object_start expected %0b got %0b",
                                                  want.object_start, got.object_start));
                    if (got.object_end !== want.object_end)
                        report_mismatch($sformatf("object_end expected %0b got %0b",
                                                  want.object_end, got.object_end));
                    if (got.current_depth !== want.current_depth)
                        report_mismatch($sformatf("current_depth expected %0d got %0d",
                                                  $signed(want.current_depth),
                                                  $signed(got.current_depth)));
                    if (m_axis_tdata[23:18] !== 6'd0)
                        report_mismatch($sformatf("pad bits expected 0 got 0x%02h",
                                                  m_axis_tdata[23:18]));
                end
                result_idx++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_byte(s_axis_tdata, want);
                expected_marks.push_back(want);
            end
            if (cfg_wr_en)
                split_lvl = cfg_wr_data;
            outstanding = expected_marks.size();
        end
    end

endmodule

// ----- dv/xml_object_boundary_scanner_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_object_boundary_scanner_tb
// Byte stream stimulus for the XML object boundary scanner.
// A short directed stream covers the first '<', begin, self-closing and end
// tags, comments, CDATA, processing instructions and extreme byte values.
// Random phases follow at split_depth 0, 2, 1, 255 with deep nesting, a
// random value and 3, built from mostly well-formed markup with noise and
// broken constructs mixed in. The sender idles in bursts and the receiver
// stalls on a changing pattern; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module xml_object_boundary_scanner_tb;
    import xobs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [7:0]  cfg_wr_data   = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    int          mismatches;
    int          outstanding;
    logic [7:0]  stim_q[$];
    int          burst_left    = 0;
    int          gen_lvl       = 0;
    int          stall_ctr     = 0;
    int          stall_mode    = 0;
    int          cycle_cnt     = 0;

    always #1 clk = ~clk;

    xml_object_boundary_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    xobs_scan_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always @(negedge clk)
    begin
        stall_ctr++;
        if (stall_ctr % 48 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready = 1'b1;
            1:       m_axis_tready = 1'($urandom_range(0, 1));
            2:       m_axis_tready = (stall_ctr % 4 == 0);
            default: m_axis_tready = ($urandom_range(0, 99) < 85);
        endcase
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("xml_object_boundary_scanner test failed");
        $finish;
    end

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            stim_q.push_back(s[i]);
    endtask

    task automatic push_name();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                stim_q.push_back(8'($urandom_range(0, 255)));
            else
                stim_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
        end
    endtask

    task automatic push_body(input logic [7:0] a, input logic [7:0] b, input int max_n);
        int n;
        n = $urandom_range(0, max_n);
        repeat (n)
        begin
            case ($urandom_range(0, 2))
                0:       stim_q.push_back(a);
                1:       stim_q.push_back(b);
                default: stim_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
            endcase
        end
    endtask

    task automatic push_open();
        push_str("<");
        push_name();
        push_str(">");
        gen_lvl++;
    endtask

    task automatic push_close();
        push_str("</");
        push_name();
        push_str(">");
        gen_lvl--;
    endtask

    task automatic gen_markup(input int n_items, input int target);
        int         stop;
        int         pick;
        logic [7:0] b;
        stop = stim_q.size() + n_items;
        while (stim_q.size() < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                if (gen_lvl <= target + 1)
                    push_open();
                else
                    push_close();
            end
            else if (pick < 50)
            begin
                if (gen_lvl > 0 || $urandom_range(0, 3) == 0)
                    push_close();
                else
                    push_open();
            end
            else if (pick < 58)
            begin
                push_str("<");
                push_name();
                push_str("/>");
            end
            else if (pick < 64)
            begin
                push_str("<!--");
                push_body(CH_DASH, CH_GT, 6);
                push_str("-->");
            end
            else if (pick < 69)
            begin
                push_str("<?");
                push_body(CH_QUEST, CH_SLASH, 5);
                push_str("?>");
            end
            else if (pick < 74)
            begin
                push_str("<![CDATA[");
                push_body(CH_RBRACK, CH_GT, 6);
                push_str("]]>");
            end
            else if (pick < 86)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    b = 8'($urandom_range(0, 255));
                    stim_q.push_back((b == CH_LT) ? 8'h20 : b);
                end
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 3))
                    stim_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       push_str("<>");
                    1:       push_str("<!>");
                    2:       push_str("<!x");
                    3:       push_str("<!-z");
                    default: push_str("</");
                endcase
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  = b;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_all();
        while (stim_q.size() != 0)
        begin
            if ($urandom_range(0, 399) == 0)
                drain();
            send_byte(stim_q.pop_front());
        end
    endtask

    task automatic write_split(input logic [7:0] v);
        drain();
        cfg_wr_data = v;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    initial
    begin
        logic [7:0] split_v;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        stim_q.push_back(8'h00);
        stim_q.push_back(8'hFF);
        push_str("<a><b/><!----><![]]><?></a>");
        send_all();

        write_split(8'd1);
        push_str("<a><b/></a>");
        send_all();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       split_v = 8'd0;
                1:       split_v = 8'd2;
                2:       split_v = 8'd1;
                3:       split_v = 8'd255;
                4:       split_v = 8'($urandom_range(3, 254));
                default: split_v = 8'd3;
            endcase
            write_split(split_v);
            if (split_v == 8'd255)
            begin
                while (gen_lvl < 254)
                begin
                    push_str("<a>");
                    gen_lvl++;
                end
                gen_markup(60, 255);
            end
            else
            begin
                gen_markup(60, int'(split_v));
            end
            send_all();
        end

        drain();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("xml_object_boundary_scanner test passed");
        else
            $display("xml_object_boundary_scanner test failed");
        $finish;
    end

endmodule
